>>> design/binomial_coefficient_defines.svh
// Assertion macros for the binomial coefficient block.
// Included by design/binomial_coefficient.sv; assumes a clk and arst_n in scope.
`ifndef BINOMIAL_COEFFICIENT_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define BC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Antecedent implies consequent in the following cycle.
`define BC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BC_ASSERT_SAME(label, ante, cons, msg)
`define BC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> design/bc_pkg.sv
// Shared constants for the binomial coefficient block.
// No dependencies.
package bc_pkg;
	// Width of the coefficient result field.
	localparam int COEF_BITS = 32;
endpackage

>>> design/binomial_coefficient.sv
// Binomial coefficient C(n, r) by the multiplicative rule, bit serial.
// r > n, r = 0 and r = n are answered straight from idle; otherwise each step i = 1..r
// runs a shift-add multiply by n - i + 1, then a restoring divide by i over WORD_BITS bits,
// and the quotient of step r is reported as the coefficient.
// One item at a time: busy drops as done rises, so the next start may follow at once.
// arst_n clears the controller to idle; results cannot be stalled.
`include "binomial_coefficient_defines.svh"

module binomial_coefficient
	import bc_pkg::*;
#(
	parameter int WORD_BITS  = 32,
	parameter int COUNT_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [COUNT_BITS-1:0] n_total,
	input  logic [COUNT_BITS-1:0] r_choose,
	output logic                  done,
	output logic [COEF_BITS-1:0]  coefficient
);

	localparam int CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV
	} state_t;

	state_t                state_q;
	logic [COUNT_BITS-1:0] n_q;
	logic [COUNT_BITS-1:0] r_q;
	logic [COUNT_BITS-1:0] i_q;
	logic [COUNT_BITS-1:0] factor_q;
	logic [WORD_BITS-1:0]  mcand_q;
	logic [WORD_BITS-1:0]  prod_q;
	logic [WORD_BITS-1:0]  dvd_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  done_q;
	logic [COEF_BITS-1:0]  coef_q;

	logic [COUNT_BITS:0]   trial;
	logic                  q_bit;
	logic [COUNT_BITS:0]   rem_diff;
	logic [WORD_BITS-1:0]  dvd_next;
	logic [COEF_BITS-1:0]  dvd_fit;

	// One restoring division step: bring down the next dividend bit.
	assign trial    = {rem_q, dvd_q[WORD_BITS-1]};
	assign q_bit    = (trial >= {1'b0, i_q});
	assign rem_diff = trial - {1'b0, i_q};
	assign dvd_next = {dvd_q[WORD_BITS-2:0], q_bit};

	generate
		if (WORD_BITS >= COEF_BITS) begin : g_trunc
			assign dvd_fit = dvd_next[COEF_BITS-1:0];
		end else begin : g_extend
			assign dvd_fit = {{(COEF_BITS-WORD_BITS){1'b0}}, dvd_next};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			coef_q   <= '0;
			n_q      <= '0;
			r_q      <= '0;
			i_q      <= '0;
			factor_q <= '0;
			mcand_q  <= '0;
			prod_q   <= '0;
			dvd_q    <= '0;
			rem_q    <= '0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						n_q <= n_total;
						r_q <= r_choose;
						if (r_choose > n_total) begin
							coef_q <= '0;
							done_q <= 1'b1;
						end else if (r_choose == '0 || r_choose == n_total) begin
							coef_q <= COEF_BITS'(1);
							done_q <= 1'b1;
						end else begin
							// First step multiplies the unit accumulator by n.
							i_q      <= COUNT_BITS'(1);
							factor_q <= n_total;
							mcand_q  <= WORD_BITS'(1);
							prod_q   <= '0;
							state_q  <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (factor_q == '0) begin
						dvd_q   <= prod_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						if (factor_q[0]) begin
							prod_q <= prod_q + mcand_q;
						end
						mcand_q  <= {mcand_q[WORD_BITS-2:0], 1'b0};
						factor_q <= factor_q >> 1;
					end
				end
				ST_DIV: begin
					rem_q <= q_bit ? rem_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
					dvd_q <= dvd_next;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(WORD_BITS - 1)) begin
						if (i_q == r_q) begin
							coef_q  <= dvd_fit;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							// Next factor is n - (i + 1) + 1.
							mcand_q  <= dvd_next;
							factor_q <= n_q - i_q;
							prod_q   <= '0;
							i_q      <= i_q + COUNT_BITS'(1);
							state_q  <= ST_MUL;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign coefficient = coef_q;

	`BC_ASSERT_NEXT(a_over_zero, start && !busy && (r_choose > n_total), done && coefficient == '0, "choice above set must give zero at once")
	`BC_ASSERT_NEXT(a_empty_one, start && !busy && (r_choose == '0), done && coefficient == COEF_BITS'(1), "empty choice must give one at once")
	`BC_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while a step is still running")
	`BC_ASSERT_SAME(a_div_nonzero, state_q == ST_DIV, i_q != '0 && i_q <= r_q, "divisor outside one to r")

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for binomial_coefficient: a directed table, then random (n, r) pairs.
// Depends on bc_pkg and the binomial_coefficient RTL; expected values come from a local model.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bc_pkg::*;

	localparam int N_BITS = 10;
	localparam int ACC_BITS = 32;
	localparam int CLK_PERIOD = 12;
	localparam int RANDOM_ITEMS = 100;
	localparam int STEP_CYCLES = 64;
	localparam longint unsigned CYCLE_LIMIT = 3_000_000;

	typedef struct {
		logic [N_BITS-1:0] n;
		logic [N_BITS-1:0] r;
		bit typed;
		logic [COEF_BITS-1:0] coef;
	} pair_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start;
	logic busy;
	logic [N_BITS-1:0] n_total;
	logic [N_BITS-1:0] r_choose;
	logic done;
	logic [COEF_BITS-1:0] coefficient;

	logic [COEF_BITS-1:0] coef_pending[$];
	int unsigned error_count = 0;
	int unsigned sent_count = 0;
	int unsigned checked_count = 0;
	int unsigned long_count = 0;
	longint unsigned cycle_count = 0;

	// Rows with typed = 0 take their expected value from the predictor.
	pair_row_t directed_rows[20] = '{
		'{10'd0,    10'd0,    1'b1, 32'd1},
		'{10'd1023, 10'd1023, 1'b1, 32'd1},
		'{10'd0,    10'd1023, 1'b1, 32'd0},
		'{10'd1023, 10'd0,    1'b1, 32'd1},
		'{10'd1022, 10'd1023, 1'b1, 32'd0},
		'{10'd1,    10'd1,    1'b1, 32'd1},
		'{10'd1,    10'd0,    1'b1, 32'd1},
		'{10'd2,    10'd1,    1'b1, 32'd2},
		'{10'd5,    10'd2,    1'b1, 32'd10},
		'{10'd10,   10'd5,    1'b1, 32'd252},
		'{10'd1023, 10'd1,    1'b1, 32'd1023},
		'{10'd1023, 10'd2,    1'b1, 32'd522753},
		'{10'd341,  10'd682,  1'b1, 32'd0},
		'{10'd34,   10'd17,   1'b0, 32'd0},
		'{10'd40,   10'd20,   1'b0, 32'd0},
		'{10'd100,  10'd50,   1'b0, 32'd0},
		'{10'd512,  10'd256,  1'b0, 32'd0},
		'{10'd682,  10'd341,  1'b0, 32'd0},
		'{10'd1023, 10'd511,  1'b0, 32'd0},
		'{10'd1023, 10'd1022, 1'b0, 32'd0}
	};

	binomial_coefficient dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.n_total(n_total),
		.r_choose(r_choose),
		.done(done),
		.coefficient(coefficient)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// Multiplicative rule; the product is cut to the word before each division.
	function automatic logic [COEF_BITS-1:0] binom_wrapped(input logic [N_BITS-1:0] n,
			input logic [N_BITS-1:0] r);
		logic [ACC_BITS-1:0] acc;
		logic [2*ACC_BITS-1:0] prod;
		int i;
		acc = 1;
		if (r > n)
			return '0;
		if (r == 0 || r == n)
			return 1;
		for (i = 1; i <= r; i++) begin
			prod = acc * (2*ACC_BITS)'(n - i + 1);
			acc = prod[ACC_BITS-1:0] / ACC_BITS'(i);
		end
		return acc[COEF_BITS-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [COEF_BITS-1:0] want,
			input logic [COEF_BITS-1:0] got);
		error_count++;
		$display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	// Holds start until the transfer, records the expectation, then maybe idles.
	task automatic send_pair(input logic [N_BITS-1:0] n, input logic [N_BITS-1:0] r,
			input bit typed, input logic [COEF_BITS-1:0] coef, input int idle_pct);
		int gap;
		start <= 1'b1;
		n_total <= n;
		r_choose <= r;
		do @(posedge clk); while (busy !== 1'b0);
		coef_pending = {coef_pending, (typed ? coef : binom_wrapped(n, r))};
		sent_count++;
		if (r < n && r >= 256)
			long_count++;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			// Mostly short gaps, sometimes long enough to land mid-computation.
			gap = ($urandom_range(3) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (coef_pending.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (coef_pending.size() == 0) begin
				report_mismatch("result with nothing pending", '0, coefficient);
			end else begin
				if (coefficient !== coef_pending[0])
					report_mismatch("coefficient", coef_pending[0], coefficient);
				void'(coef_pending.pop_front());
				checked_count++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results pending.", cycle_count,
				coef_pending.size());
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		logic [N_BITS-1:0] n;
		logic [N_BITS-1:0] r;
		int pick;
		int idle_pct;
		int k;
		start <= 1'b0;
		n_total <= '0;
		r_choose <= '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < $size(directed_rows); k++)
			send_pair(directed_rows[k].n, directed_rows[k].r, directed_rows[k].typed,
				directed_rows[k].coef, 0);
		drain_results();

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			idle_pct = (k < 34) ? 0 : (k < 67) ? 57 : 37;
			if (k == 34 || k == 67)
				drain_results();
			pick = $urandom_range(99);
			n = N_BITS'($urandom_range(1023));
			if (k % 25 == 12) begin
				// A few deep runs; most transfers stay short to keep the run brief.
				r = N_BITS'($urandom_range(n));
			end else if (pick < 10) begin
				n = N_BITS'($urandom_range(1022));
				r = N_BITS'($urandom_range(1023, n + 1));
			end else if (pick < 18) begin
				r = $urandom_range(1) ? '0 : n;
			end else if (pick < 40) begin
				n = N_BITS'($urandom_range(40));
				r = N_BITS'($urandom_range(n));
			end else begin
				r = N_BITS'($urandom_range(40, 1));
			end
			send_pair(n, r, 1'b0, '0, idle_pct);
		end

		start <= 1'b0;
		while (coef_pending.size() != 0)
			@(posedge clk);
		repeat (2*STEP_CYCLES) @(posedge clk);

		$display("Covered %0d transfers (%0d directed, %0d random, %0d long runs), %0d checked.",
			sent_count, $size(directed_rows), RANDOM_ITEMS, long_count, checked_count);
		$display("Sender gaps at 0, 57 and 37 percent, with full drains between phases.");
		if (error_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("%0d mismatches.", error_count);
			$display("tb_top failed");
		end
		$finish;
	end
endmodule
